// ===== hdl/cad_pkg.sv =====
// ----------------------------------------------------------------------------
// cad_pkg
// Types and constants shared by the card access door controller modules.
// ----------------------------------------------------------------------------
package cad_pkg;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_CARD   = 2'd1,
    MODE_ADMIN  = 2'd2,
    MODE_ENROLL = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE           = 3'd0,
    EV_OPEN_CARD      = 3'd1,
    EV_OPEN_ADMIN     = 3'd2,
    EV_CLOSED         = 3'd3,
    EV_ENROLLED       = 3'd4,
    EV_ENROLL_TIMEOUT = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OPEN,
    PH_ENROLL
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  localparam int          UID_W            = 32;
  localparam int          TICK_W           = 16;
  localparam logic        CFG_OPEN_TICKS   = 1'b0;
  localparam logic        CFG_ENROLL_TICKS = 1'b1;
  localparam logic [15:0] OPEN_TICKS_RST   = 16'd5000;
  localparam logic [15:0] ENROLL_TICKS_RST = 16'd8000;

  typedef struct packed {
    logic [1:0]       mode;
    logic [UID_W-1:0] card_uid;
  } in_req_t;

  typedef struct packed {
    logic [2:0]       event_res;
    logic [UID_W-1:0] event_uid;
    logic             uid_valid;
    logic             door_state;
    logic [4:0]       stored_count;
  } out_req_t;

  // Search token handed from one table cell to the next.
  typedef struct packed {
    logic             go;
    logic             hit;
    logic [UID_W-1:0] key;
  } link_t;

endpackage

// ===== hdl/cad_cell.sv =====
// ----------------------------------------------------------------------------
// cad_cell
// One entry of the authorised ID table. Compares its entry with the search
// token passing through and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module cad_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cad_pkg::link_t          link_in,
  output cad_pkg::link_t          link_out,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_idx,
  input  logic [cad_pkg::UID_W-1:0] wr_data,
  input  logic [CNT_W-1:0]        id_count
);

  logic [cad_pkg::UID_W-1:0] entry_r;
  logic [cad_pkg::UID_W-1:0] key_r;
  logic                      hit_r;
  logic                      go_r;
  logic                      live;

  // Entries at or above the fill count have not been written since reset.
  assign live = (CNT_W'(CELL_IDX) < id_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= link_in.go;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= link_in.key;
    hit_r <= link_in.hit | (live && (entry_r == link_in.key));
    if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
      entry_r <= wr_data;
    end
  end

  assign link_out = '{go: go_r, hit: hit_r, key: key_r};

endmodule

// ===== hdl/card_access_door_controller.sv =====
// ----------------------------------------------------------------------------
// card_access_door_controller
// Door controller with an authorised card table, repeat suppression, timed
// opening and an enroll mode.
// ----------------------------------------------------------------------------
// One request is handled at a time. Ticks, admin opens, enroll commands and
// card reads that need no table look-up are answered without a search. A card
// read that must be checked against the table walks a search token down a row
// of TABLE_DEPTH cells, one cell per cycle; the next request waits until the
// token has left the last cell and the result is loaded. The result sits in an
// output register, and a new request is taken in the cycle that result leaves.
// ----------------------------------------------------------------------------
module card_access_door_controller #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cad_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cad_pkg::out_req_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  cad_pkg::state_t              state_r, state_nxt;
  cad_pkg::phase_t              phase_r, phase_nxt;
  logic [cad_pkg::TICK_W-1:0]   tick_r, tick_nxt, tick_inc;
  logic [cad_pkg::UID_W-1:0]    seen_r, seen_nxt;
  logic [cad_pkg::UID_W-1:0]    held_uid_r, held_uid_nxt;
  logic                         held_valid_r, held_valid_nxt;
  logic                         door_r, door_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [15:0]                  open_ticks_r, enroll_ticks_r;
  logic [cad_pkg::UID_W-1:0]    key_r;
  logic                         hit_r;
  logic                         out_valid_r, out_valid_nxt;
  cad_pkg::out_req_t            out_data_r;

  logic                         out_free;
  logic                         start;
  logic                         out_load;
  logic                         tbl_wr;
  cad_pkg::event_t              ev;
  logic [cad_pkg::UID_W-1:0]    ev_uid;
  logic                         ev_valid;

  cad_pkg::link_t               links [0:TABLE_DEPTH];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == cad_pkg::ST_ACCEPT) && out_free;
  assign tick_inc = tick_r + cad_pkg::TICK_W'(1);

  // ---------------------------------------------------------------------------
  // Table cells
  // ---------------------------------------------------------------------------
  assign links[0] = '{go: start, hit: 1'b0, key: in_data.card_uid};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cad_cell #(
      .CELL_IDX (i),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .wr_en    (tbl_wr),
      .wr_idx   (count_r[IDX_W-1:0]),
      .wr_data  (key_r),
      .id_count (count_r)
    );
  end

  // ---------------------------------------------------------------------------
  // Request handling
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    seen_nxt       = seen_r;
    held_uid_nxt   = held_uid_r;
    held_valid_nxt = held_valid_r;
    door_nxt       = door_r;
    count_nxt      = count_r;
    ev             = cad_pkg::EV_NONE;
    ev_uid         = '0;
    ev_valid       = 1'b0;
    start          = 1'b0;
    out_load       = 1'b0;
    tbl_wr         = 1'b0;

    unique case (state_r)
      cad_pkg::ST_ACCEPT: begin
        if (in_valid && out_free) begin
          unique case (cad_pkg::mode_t'(in_data.mode))
            cad_pkg::MODE_TICK: begin
              if (phase_r == cad_pkg::PH_OPEN) begin
                tick_nxt = tick_inc;
                if (tick_inc >= open_ticks_r) begin
                  door_nxt       = 1'b0;
                  ev             = cad_pkg::EV_CLOSED;
                  ev_valid       = held_valid_r;
                  ev_uid         = held_valid_r ? held_uid_r : '0;
                  held_valid_nxt = 1'b0;
                  seen_nxt       = '0;
                  phase_nxt      = cad_pkg::PH_IDLE;
                end
              end else if (phase_r == cad_pkg::PH_ENROLL) begin
                tick_nxt = tick_inc;
                if (tick_inc >= enroll_ticks_r) begin
                  ev             = cad_pkg::EV_ENROLL_TIMEOUT;
                  held_valid_nxt = 1'b0;
                  seen_nxt       = '0;
                  phase_nxt      = cad_pkg::PH_IDLE;
                end
              end
            end
            cad_pkg::MODE_CARD: begin
              // Only a new card outside the open phase needs a table look-up.
              if (phase_r != cad_pkg::PH_OPEN && in_data.card_uid != seen_r) begin
                start     = 1'b1;
                state_nxt = cad_pkg::ST_SEARCH;
              end
            end
            cad_pkg::MODE_ADMIN: begin
              if (phase_r != cad_pkg::PH_ENROLL) begin
                door_nxt  = 1'b1;
                tick_nxt  = '0;
                phase_nxt = cad_pkg::PH_OPEN;
                ev        = cad_pkg::EV_OPEN_ADMIN;
              end
            end
            default: begin
              if (phase_r == cad_pkg::PH_IDLE) begin
                phase_nxt = cad_pkg::PH_ENROLL;
                tick_nxt  = '0;
                seen_nxt  = '0;
              end
            end
          endcase
          out_load = !start;
        end
      end
      cad_pkg::ST_SEARCH: begin
        if (links[TABLE_DEPTH].go) begin
          state_nxt = cad_pkg::ST_FINISH;
        end
      end
      cad_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = cad_pkg::ST_ACCEPT;
          seen_nxt  = key_r;
          ev_uid    = key_r;
          ev_valid  = 1'b1;
          if (phase_r == cad_pkg::PH_IDLE) begin
            held_uid_nxt   = key_r;
            held_valid_nxt = 1'b1;
            if (hit_r) begin
              door_nxt  = 1'b1;
              tick_nxt  = '0;
              phase_nxt = cad_pkg::PH_OPEN;
              ev        = cad_pkg::EV_OPEN_CARD;
            end else begin
              ev_uid   = '0;
              ev_valid = 1'b0;
            end
          end else begin
            // Enroll: a card already stored or a full table leaves it as it is.
            if ((count_r < CNT_W'(TABLE_DEPTH)) && !hit_r) begin
              tbl_wr    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
            ev             = cad_pkg::EV_ENROLLED;
            held_valid_nxt = 1'b0;
            seen_nxt       = '0;
            phase_nxt      = cad_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        state_nxt = cad_pkg::ST_ACCEPT;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= cad_pkg::ST_ACCEPT;
      phase_r        <= cad_pkg::PH_IDLE;
      tick_r         <= '0;
      seen_r         <= '0;
      held_uid_r     <= '0;
      held_valid_r   <= 1'b0;
      door_r         <= 1'b0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      open_ticks_r   <= cad_pkg::OPEN_TICKS_RST;
      enroll_ticks_r <= cad_pkg::ENROLL_TICKS_RST;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      tick_r       <= tick_nxt;
      seen_r       <= seen_nxt;
      held_uid_r   <= held_uid_nxt;
      held_valid_r <= held_valid_nxt;
      door_r       <= door_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == cad_pkg::CFG_OPEN_TICKS) begin
          open_ticks_r <= cfg_wdata;
        end else begin
          enroll_ticks_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= in_data.card_uid;
    end
    if (state_r == cad_pkg::ST_SEARCH && links[TABLE_DEPTH].go) begin
      hit_r <= links[TABLE_DEPTH].hit;
    end
    if (out_load) begin
      out_data_r <= '{event_res:    ev,
                      event_uid:    ev_uid,
                      uid_valid:    ev_valid,
                      door_state:   door_nxt,
                      stored_count: 5'(count_nxt)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
